FILE: rtl/ifd_pkg.sv
// Shared types and constants for the interleaved frame deframer.
package ifd_pkg;

    localparam logic [7:0] MARKER_BYTE = 8'h24;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_CHAN   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_PASS   = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] chan_id;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       empty_frame;
        logic       too_long;
    } result_t;

endpackage

FILE: rtl/ifd_parser.sv
// Frame header parser: phase machine, header capture and per-byte result.
module ifd_parser import ifd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  in_byte,
    input  logic [15:0] max_payload,
    output result_t     result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  chan_reg, chan_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [15:0] bytes_left_reg, bytes_left_next;

    logic [15:0] frame_len;
    logic [15:0] left_dec;

    assign frame_len = {len_high_reg, in_byte};
    assign left_dec  = bytes_left_reg - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            chan_reg       <= 8'd0;
            len_high_reg   <= 8'd0;
            bytes_left_reg <= 16'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            chan_reg       <= chan_next;
            len_high_reg   <= len_high_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // next state
    always_comb begin
        phase_next      = phase_reg;
        chan_next       = chan_reg;
        len_high_next   = len_high_reg;
        bytes_left_next = bytes_left_reg;
        case (phase_reg)
            PH_CHAN: begin
                chan_next  = in_byte;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_high_next = in_byte;
                phase_next    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                bytes_left_next = frame_len;
                if (frame_len == 16'd0) begin
                    phase_next = PH_HUNT;
                end else if (frame_len > max_payload) begin
                    phase_next = PH_SKIP;
                end else begin
                    phase_next = PH_PASS;
                end
            end
            PH_PASS, PH_SKIP: begin
                bytes_left_next = left_dec;
                if (left_dec == 16'd0) begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                // unused codes behave as hunting
                phase_next = (in_byte == MARKER_BYTE) ? PH_CHAN : PH_HUNT;
            end
        endcase
    end

    // result for the byte at hand
    always_comb begin
        result              = '0;
        result.chan_id      = chan_reg;
        case (phase_reg)
            PH_LEN_LO: begin
                if (frame_len == 16'd0) begin
                    result.valid       = 1'b1;
                    result.frame_end   = 1'b1;
                    result.empty_frame = 1'b1;
                end else if (frame_len > max_payload) begin
                    result.valid     = 1'b1;
                    result.frame_end = 1'b1;
                    result.too_long  = 1'b1;
                end
            end
            PH_PASS: begin
                result.valid        = 1'b1;
                result.payload_byte = in_byte;
                result.frame_end    = (left_dec == 16'd0);
            end
            default: begin
                result.valid = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/interleaved_frame_deframer_core.sv
// Interleaved frame deframer top level: input register, parser, result register.
//
// Takes one stream byte per cycle when not stalled and emits at most one
// result per byte: each payload byte tagged with its channel (tlast on the
// final one), or a single flagged result for an empty or too-long frame. A
// byte accepted into the input register is parsed from it, and its result is
// captured in the output register when the parser advances, while the next
// byte can be accepted. Backpressure on m_tready stalls the parser and,
// through the input register, s_tready. The user must write max_payload on
// the cfg channel only while the block is idle; the block does not enforce it.
module interleaved_frame_deframer_core import ifd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] chan_id, [15:8] payload_byte
    output logic        m_tlast,   // frame_end
    output logic [1:0]  m_tuser,   // [0] empty_frame, [1] too_long
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // max_payload
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    logic [15:0] max_payload_reg;
    logic        advance;
    result_t     result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    ifd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_byte     (in_byte_reg),
        .max_payload (max_payload_reg),
        .result      (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (advance) begin
            out_valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            max_payload_reg <= 16'd19996;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                max_payload_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && result.valid) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.payload_byte, out_res_reg.chan_id};
    assign m_tlast  = out_res_reg.frame_end;
    assign m_tuser  = {out_res_reg.too_long, out_res_reg.empty_frame};

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("empty_frame and too_long both set");

    a_flag_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> (m_tlast && m_tdata[15:8] == 8'd0))
        else $error("flagged request not a zero-data frame end");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> !$past(advance))
        else $error("parser advanced into a stalled output register");
`endif

endmodule
